@@ design/spc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg: shared constants for the sphere pair contact block
// Holds the fixed normal format and the min_length register format.
// ----------------------------------------------------------------------------
package spc_pkg;
    localparam int NORM_FRAC  = 30;
    localparam int NORM_WIDTH = 32;
    localparam int MINLEN_WIDTH = 16;
    localparam int MINLEN_RESET = 1;
endpackage

@@ design/sphere_pair_contact.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_pair_contact: sphere against sphere contact test
// Distance by a chain of root cells, normal by a chain of divider cells.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  s_axis   | in  | centres and radii of spheres A and B
//  m_axis   | out | contact, overlap, normal, contact point
//  cfg      | in  | min_length write
//
//  One transaction per cycle enters while the pipeline is not stalled; the
//  pipeline is COORD_WIDTH+2 root cells plus 31 divider cells plus five
//  arithmetic stages.
//  The whole pipeline advances only when the output register is free or taken.
//  Reset clears the valid bits of every stage and sets min_length to 1.
module sphere_pair_contact
    import spc_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    // Scaling of the normal and the point does not depend on the fraction bits.
    parameter int FRAC_BITS   = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // a_x, a_y, a_z, radius_a, b_x, b_y, b_z, radius_b
    input  logic [((8*COORD_WIDTH-2+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // contact, overlap, normal_x/y/z, point_x/y/z
    output logic [((1+4*COORD_WIDTH+3*NORM_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic cfg_we,
    input  logic [MINLEN_WIDTH-1:0] cfg_wdata
);
    localparam int CW = COORD_WIDTH;
    localparam int DMW = CW + 1;           // |d| magnitude width
    localparam int SQW = 2 * DMW + 2;      // sum of squares width
    localparam int RTB = DMW + 1;          // root bits
    localparam int QW  = NORM_FRAC + 1;    // quotient bits
    localparam int DRW = DMW + 1 + QW;     // divider remainder width
    localparam int DEP = 3 + RTB + QW + 2; // pipeline stages

    logic en;
    logic [DEP-1:0] vld_reg;
    logic [MINLEN_WIDTH-1:0] minlen_reg;

    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            minlen_reg <= MINLEN_WIDTH'(MINLEN_RESET);
        end else begin
            if (cfg_we) minlen_reg <= cfg_wdata;
            if (en) vld_reg <= {vld_reg[DEP-2:0], s_tvalid};
        end
    end
    assign m_tvalid = vld_reg[DEP-1];

    // Side data carried beside the chains, one register per stage.
    typedef struct packed {
        logic [2:0]           neg;
        logic [2:0][DMW-1:0]  mag;
        logic [2:0][CW-1:0]   cb;
        logic [CW-1:0]        rb;
        logic [CW:0]          rsum;
        logic                 hit;
    } side_t;

    // Stage 0: differences.
    side_t s0_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [DMW-1:0] d;
                d = DMW'($signed(s_tdata[i*CW +: CW])) -
                    DMW'($signed(s_tdata[(4*CW-1)+i*CW +: CW]));
                s0_reg.neg[i] <= d[DMW-1];
                s0_reg.mag[i] <= d[DMW-1] ? DMW'(-d) : DMW'(d);
                s0_reg.cb[i]  <= s_tdata[(4*CW-1)+i*CW +: CW];
            end
            s0_reg.rb   <= {1'b0, s_tdata[7*CW-1 +: CW-1]};
            s0_reg.rsum <= (CW+1)'(s_tdata[3*CW +: CW-1]) +
                           (CW+1)'(s_tdata[7*CW-1 +: CW-1]);
            s0_reg.hit  <= 1'b0;
        end
    end

    // Stage 1: squares.
    side_t s1_reg;
    logic [2:0][SQW-1:0] sq_reg;
    logic [SQW-1:0] rsq_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s0_reg;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= SQW'(s0_reg.mag[i]) * SQW'(s0_reg.mag[i]);
            rsq_reg <= SQW'(s0_reg.rsum) * SQW'(s0_reg.rsum);
        end
    end

    // Stage 2: sum and contact compare.
    side_t s2_reg;
    logic [SQW-1:0] ss_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            logic [SQW-1:0] ss;
            side_t sd;
            ss = sq_reg[0] + sq_reg[1] + sq_reg[2];
            sd = s1_reg;
            sd.hit = !(ss > rsq_reg);
            s2_reg <= sd;
            ss_reg <= ss;
        end
    end

    // Root chain.
    side_t sd_r [RTB+1];
    logic [SQW-1:0] rem_r  [RTB+1];
    logic [SQW-1:0] root_r [RTB+1];
    assign sd_r[0]   = s2_reg;
    assign rem_r[0]  = ss_reg;
    assign root_r[0] = '0;
    for (genvar k = 0; k < RTB; k++) begin : g_rt
        spc_sqrt_cell #(.RW(SQW), .BIT(RTB-1-k)) u_cell (
            .aclk(aclk), .en(en), .rem_in(rem_r[k]), .root_in(root_r[k]),
            .rem_reg(rem_r[k+1]), .root_reg(root_r[k+1]));
        always_ff @(posedge aclk) if (en) sd_r[k+1] <= sd_r[k];
    end

    // Divider setup.
    logic [DMW:0] len_w;
    assign len_w = root_r[RTB][DMW:0];
    side_t sd_d [QW+1];
    logic [2:0][DRW-1:0] drem [QW+1];
    logic [2:0][QW-1:0]  dq   [QW+1];
    logic [DMW:0]        dlen [QW+1];
    logic                ddef [QW+1];
    assign sd_d[0] = sd_r[RTB];
    assign dlen[0] = len_w;
    assign ddef[0] = !(len_w > (DMW+1)'(minlen_reg));
    assign dq[0]   = '0;
    for (genvar i = 0; i < 3; i++) begin : g_num
        assign drem[0][i] = (DRW'(sd_r[RTB].mag[i]) << NORM_FRAC) + DRW'(len_w >> 1);
    end
    for (genvar k = 0; k < QW; k++) begin : g_dv
        spc_div_cell #(.DW(DMW+1), .QW(QW), .BIT(QW-1-k)) u_cell (
            .aclk(aclk), .en(en), .den(ddef[k] ? (DMW+1)'(1) : dlen[k]),
            .rem_in(drem[k]), .q_in(dq[k]), .rem_reg(drem[k+1]),
            .q_reg(dq[k+1]));
        always_ff @(posedge aclk) begin
            if (en) begin
                sd_d[k+1] <= sd_d[k];
                dlen[k+1] <= dlen[k];
                ddef[k+1] <= ddef[k];
            end
        end
    end

    // Normal and offset product.
    side_t sn_reg;
    logic signed [2:0][NORM_WIDTH-1:0] nrm_reg;
    logic [2:0][CW+QW:0] prod_reg;
    logic def_reg;
    logic [CW:0] ovl_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sn_reg  <= sd_d[QW];
            def_reg <= ddef[QW];
            ovl_reg <= sd_d[QW].rsum - (CW+1)'(dlen[QW]);
            for (int i = 0; i < 3; i++) begin
                logic [QW-1:0] nm;
                nm = ddef[QW] ? ((i == 0) ? QW'(1) << NORM_FRAC : '0) : dq[QW][i];
                nrm_reg[i]  <= (sd_d[QW].neg[i] && !ddef[QW]) ?
                               -NORM_WIDTH'(nm) : NORM_WIDTH'(nm);
                prod_reg[i] <= (CW+QW+1)'(sd_d[QW].rb[CW-2:0]) * (CW+QW+1)'(nm) +
                               ((CW+QW+1)'(1) << (NORM_FRAC-1));
            end
        end
    end

    // Output register: point with saturation.
    logic [$bits(m_tdata)-1:0] out_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            logic signed [CW+1:0] p;
            logic [CW:0] off;
            logic [$bits(m_tdata)-1:0] o;
            o = '0;
            if (sn_reg.hit) begin
                o[0] = 1'b1;
                o[1 +: CW] = ovl_reg[CW-1:0];
                for (int i = 0; i < 3; i++) begin
                    off = prod_reg[i][NORM_FRAC +: CW+1];
                    p = (CW+2)'($signed(sn_reg.cb[i])) +
                        (nrm_reg[i][NORM_WIDTH-1] ? -$signed({1'b0, off})
                                                  : $signed({1'b0, off}));
                    if (p > $signed((CW+2)'({1'b0, {(CW-1){1'b1}}})))
                        p = (CW+2)'({1'b0, {(CW-1){1'b1}}});
                    if (p < -$signed((CW+2)'({1'b1, {(CW-1){1'b0}}})))
                        p = -$signed((CW+2)'({1'b1, {(CW-1){1'b0}}}));
                    o[1+CW+i*NORM_WIDTH +: NORM_WIDTH] = nrm_reg[i];
                    o[1+CW+3*NORM_WIDTH+i*CW +: CW] = p[CW-1:0];
                end
            end
            out_reg <= o;
        end
    end
    assign m_tdata = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[CW:1] == '0)
        else $error("overlap without contact");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
endmodule

@@ design/spc_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_sqrt_cell: one root bit of a restoring square root
// Trial subtraction on the radicand remainder; hands root and remainder on.
// ----------------------------------------------------------------------------
module spc_sqrt_cell #(
    parameter int RW  = 66,
    parameter int BIT = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [RW-1:0] rem_in,
    input  logic [RW-1:0] root_in,
    output logic [RW-1:0] rem_reg,
    output logic [RW-1:0] root_reg
);
    logic [RW-1:0] trial;
    logic          take;
    logic [RW-1:0] rem_next;
    logic [RW-1:0] root_next;

    // Root is kept shifted: trial = (root << (BIT+1)) | (1 << 2*BIT).
    always_comb begin
        trial     = (root_in << (BIT + 1)) | (RW'(1) << (2 * BIT));
        take      = rem_in >= trial;
        rem_next  = take ? rem_in - trial : rem_in;
        root_next = take ? (root_in | (RW'(1) << BIT)) : root_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end
endmodule

@@ design/spc_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_div_cell: one quotient bit of a restoring divider
// Three lanes share the divisor; each cell settles one bit of each quotient.
// ----------------------------------------------------------------------------
module spc_div_cell #(
    parameter int DW  = 33,
    parameter int QW  = 31,
    parameter int BIT = 0
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [DW-1:0]         den,
    input  logic [2:0][DW+QW-1:0] rem_in,
    input  logic [2:0][QW-1:0]    q_in,
    output logic [2:0][DW+QW-1:0] rem_reg,
    output logic [2:0][QW-1:0]    q_reg
);
    localparam int RW = DW + QW;
    logic [2:0][RW-1:0] rem_next;
    logic [2:0][QW-1:0] q_next;
    logic [RW-1:0]      sh;

    always_comb begin
        sh = RW'(den) << BIT;
        for (int i = 0; i < 3; i++) begin
            if (rem_in[i] >= sh) begin
                rem_next[i] = rem_in[i] - sh;
                q_next[i]   = q_in[i] | (QW'(1) << BIT);
            end else begin
                rem_next[i] = rem_in[i];
                q_next[i]   = q_in[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end
endmodule
